// ===== src/egas_pkg.sv =====
// Package for the epsilon-greedy arm selector: types, codes and constants.
// No dependencies.
`default_nettype none
package egas_pkg;

  localparam int unsigned CurWidth  = 24;
  localparam int unsigned QWidth    = 17;
  localparam int unsigned CntWidth  = 16;
  localparam int unsigned AccWidth  = 32;
  localparam int unsigned RateWidth = 16;
  localparam int unsigned ArmWidth  = 3;

  localparam logic [QWidth-1:0]    OneQ16      = 17'd65536;
  localparam logic [RateWidth-1:0] RateReset   = 16'd62259;
  localparam logic [RateWidth-1:0] RateCleared = 16'd58982;

  // Explore rate decay: floor(rate * 100 / 101) equals
  // (rate * RateScale) >> RateShift for every 16-bit rate.
  localparam logic [30:0]          RateScale   = 31'd1063110800;
  localparam int unsigned          RateShift   = 30;

  typedef enum logic [1:0] {
    FuncAdd    = 2'd0,
    FuncDecide = 2'd1,
    FuncClear  = 2'd2,
    FuncNone   = 2'd3
  } func_e;

  typedef enum logic {
    RegCurLow  = 1'b0,
    RegCurHigh = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRatioStart,
    StRatioWait,
    StNormStart,
    StNormWait,
    StUpdStart,
    StUpdWait,
    StRate,
    StScan,
    StOut
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic div_ratio;
    logic div_norm;
    logic div_upd;
    logic store_ratio;
    logic store_norm;
    logic store_upd;
    logic store_rate;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic    div_done;
    logic    scan_done;
    logic    explore;
    func_e   func;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/egas_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on no package.
`default_nettype none
module egas_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = quo_d;
endmodule
`default_nettype wire

// ===== src/egas_ctrl.sv =====
// Controller state machine of the arm selector.
// Depends on egas_pkg.
`default_nettype none
module egas_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire egas_pkg::sts_t  sts_i,
  output egas_pkg::cmd_t       cmd_o
);
  egas_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      egas_pkg::StIdle:
        if (in_valid_i) state_d = egas_pkg::StRatioStart;
      egas_pkg::StRatioStart: begin
        if (sts_i.func == egas_pkg::FuncDecide) state_d = egas_pkg::StRatioWait;
        else state_d = egas_pkg::StIdle;
      end
      egas_pkg::StRatioWait: if (sts_i.div_done) state_d = egas_pkg::StNormStart;
      egas_pkg::StNormStart: state_d = egas_pkg::StNormWait;
      egas_pkg::StNormWait:  if (sts_i.div_done) state_d = egas_pkg::StUpdStart;
      egas_pkg::StUpdStart:  state_d = egas_pkg::StUpdWait;
      egas_pkg::StUpdWait: begin
        if (sts_i.div_done) begin
          if (sts_i.explore) state_d = egas_pkg::StRate;
          else state_d = egas_pkg::StScan;
        end
      end
      egas_pkg::StRate:      state_d = egas_pkg::StOut;
      egas_pkg::StScan:      if (sts_i.scan_done) state_d = egas_pkg::StOut;
      egas_pkg::StOut:       if (out_ready_i) state_d = egas_pkg::StIdle;
      default:               state_d = egas_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      egas_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      egas_pkg::StRatioStart: cmd_o.div_ratio = 1'b1;
      egas_pkg::StRatioWait:  cmd_o.store_ratio = sts_i.div_done;
      egas_pkg::StNormStart:  cmd_o.div_norm = 1'b1;
      egas_pkg::StNormWait:   cmd_o.store_norm = sts_i.div_done;
      egas_pkg::StUpdStart:   cmd_o.div_upd = 1'b1;
      egas_pkg::StUpdWait: begin
        cmd_o.store_upd  = sts_i.div_done;
        cmd_o.scan_start = sts_i.div_done && !sts_i.explore;
      end
      egas_pkg::StRate:       cmd_o.store_rate = 1'b1;
      egas_pkg::StScan:       cmd_o.scan_step = 1'b1;
      egas_pkg::StOut: begin
        out_valid_o  = 1'b1;
        cmd_o.finish = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= egas_pkg::StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== src/egas_dp.sv =====
// Datapath of the arm selector: accumulators, estimate tables, shared divider.
// Depends on egas_pkg and egas_div.
`default_nettype none
module egas_dp #(
  parameter int unsigned NumArms = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire egas_pkg::cmd_t cmd_i,
  output egas_pkg::sts_t     sts_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [23:0]   cfg_data_i,
  input  wire logic [1:0]    func_i,
  input  wire logic [15:0]   success_count_i,
  input  wire logic [15:0]   total_count_i,
  input  wire logic [23:0]   measured_current_i,
  input  wire logic [15:0]   explore_draw_i,
  input  wire logic [2:0]    explore_arm_i,
  output logic [2:0]         next_arm_o,
  output logic [16:0]        reward_o,
  output logic               explored_o
);
  localparam int unsigned AW = (NumArms > 1) ? $clog2(NumArms) : 1;
  localparam int unsigned NW = 48;
  localparam int unsigned DW = 32;

  logic [23:0] cur_low_q, cur_high_q;
  logic [31:0] succ_q, pkt_q;
  logic [16:0] est_q [NumArms];
  logic [15:0] cnt_q [NumArms];
  logic [15:0] rate_q;
  logic [AW-1:0] arm_q;

  logic [1:0]  func_q;
  logic [23:0] cur_q;
  logic [15:0] draw_q;
  logic [2:0]  earm_q;

  logic [16:0] ratio_q, norm_q;
  logic        sub_q;
  logic [16:0] oldest_q;
  logic [AW-1:0] scan_q, best_q;
  logic [2:0]  next_q;
  logic        expl_q;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  logic [16:0] reward;
  logic [18:0] rsum;
  logic [16:0] est_cur;
  logic [16:0] mag;
  logic [15:0] cnt_new;
  logic [16:0] ratio_cl;
  logic [23:0] cdiff, crange;
  logic [32:0] sadd, padd;
  logic [2:0]  earm_mod;
  logic [AW-1:0] earm_idx;
  logic [46:0] rate_prod;

  assign rsum    = 19'(3) * {2'b0, ratio_q} + 19'(egas_pkg::OneQ16) - {2'b0, norm_q};
  assign reward  = rsum[18:2];
  assign est_cur = est_q[arm_q];
  assign mag     = (reward >= est_cur) ? reward - est_cur : est_cur - reward;
  assign cnt_new = (cnt_q[arm_q] == 16'hFFFF) ? 16'hFFFF : cnt_q[arm_q] + 16'd1;
  assign cdiff   = cur_q - cur_low_q;
  assign crange  = cur_high_q - cur_low_q;
  assign sadd    = {1'b0, succ_q} + 33'(success_count_i);
  assign padd    = {1'b0, pkt_q} + 33'(total_count_i);
  // Reciprocal multiplication in place of a division by 101.
  assign rate_prod = 47'(rate_q) * 47'(egas_pkg::RateScale);
  // explore_arm is at most 7, so one conditional subtraction per step suffices.
  always_comb begin
    earm_mod = earm_q;
    if (earm_mod >= 3'(NumArms)) earm_mod = earm_mod - 3'(NumArms);
    if (earm_mod >= 3'(NumArms)) earm_mod = earm_mod - 3'(NumArms);
    if (earm_mod >= 3'(NumArms)) earm_mod = earm_mod - 3'(NumArms);
    earm_idx = AW'(earm_mod);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    priority if (cmd_i.div_ratio) begin
      div_start = 1'b1;
      div_num   = {succ_q, 16'b0};
      div_den   = (pkt_q == '0) ? 32'd1 : pkt_q;
    end else if (cmd_i.div_norm) begin
      div_start = 1'b1;
      div_num   = {8'b0, cdiff, 16'b0};
      div_den   = (crange == '0) ? 32'd1 : {8'b0, crange};
    end else if (cmd_i.div_upd) begin
      div_start = 1'b1;
      div_num   = {31'b0, mag};
      div_den   = {16'b0, cnt_q[arm_q]};
    end
  end

  egas_div #(.NumW(NW), .DenW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign ratio_cl = (pkt_q == '0) ? 17'd0 :
                    (div_quo > NW'(egas_pkg::OneQ16)) ? egas_pkg::OneQ16 : div_quo[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_low_q  <= '0;
      cur_high_q <= 24'hFFFFFF;
      succ_q     <= '0;
      pkt_q      <= '0;
      rate_q     <= egas_pkg::RateReset;
      arm_q      <= '0;
      for (int i = 0; i < NumArms; i++) begin
        est_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == egas_pkg::RegCurLow) cur_low_q <= cfg_data_i;
        else cur_high_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        unique case (egas_pkg::func_e'(func_i))
          egas_pkg::FuncAdd: begin
            succ_q <= sadd[32] ? '1 : sadd[31:0];
            pkt_q  <= padd[32] ? '1 : padd[31:0];
          end
          egas_pkg::FuncClear: begin
            for (int i = 0; i < NumArms; i++) begin
              est_q[i] <= '0;
              cnt_q[i] <= '0;
            end
            rate_q <= egas_pkg::RateCleared;
          end
          default: ;
        endcase
      end
      if (cmd_i.store_norm) cnt_q[arm_q] <= cnt_new;
      if (cmd_i.store_upd) begin
        est_q[arm_q] <= sub_q ? oldest_q - div_quo[16:0] : oldest_q + div_quo[16:0];
      end
      if (cmd_i.store_rate) rate_q <= rate_prod[egas_pkg::RateShift +: 16];
      if (cmd_i.finish) begin
        arm_q  <= AW'(next_q);
        succ_q <= '0;
        pkt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= func_i;
      cur_q  <= measured_current_i;
      draw_q <= explore_draw_i;
      earm_q <= explore_arm_i;
    end
    if (cmd_i.store_ratio) ratio_q <= ratio_cl;
    if (cmd_i.store_norm) begin
      if (cur_q <= cur_low_q) norm_q <= '0;
      else if (cur_q >= cur_high_q) norm_q <= egas_pkg::OneQ16;
      else norm_q <= div_quo[16:0];
    end
    // Direction and old estimate are captured when the update division starts.
    if (cmd_i.div_upd) begin
      oldest_q <= est_cur;
      sub_q    <= reward < est_cur;
    end
    if (cmd_i.store_norm) expl_q <= (draw_q < rate_q);
    if (cmd_i.store_upd && expl_q) next_q <= 3'(earm_idx);
    if (cmd_i.scan_start) begin
      scan_q <= AW'(1);
      best_q <= '0;
    end
    if (cmd_i.scan_step) begin
      if (est_q[scan_q] > est_q[best_q]) best_q <= scan_q;
      scan_q <= scan_q + AW'(1);
      if (scan_q == AW'(NumArms - 1)) begin
        next_q <= (est_q[scan_q] > est_q[best_q]) ? 3'(scan_q) : 3'(best_q);
      end
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.scan_done = cmd_i.scan_step && (scan_q == AW'(NumArms - 1));
  assign sts_o.explore   = expl_q;
  assign sts_o.func      = egas_pkg::func_e'(func_q);
  assign next_arm_o = next_q;
  assign reward_o   = reward;
  assign explored_o = expl_q;
endmodule
`default_nettype wire

// ===== src/epsilon_greedy_arm_selector.sv =====
// Top level of the epsilon-greedy arm selector.
// Depends on egas_pkg, egas_ctrl, egas_dp and egas_div.
//
//   channel   direction  contents
//   s_axis    in         func, counts, current, draw, explore arm
//   m_axis    out        next arm, reward, explored flag
//   cfg       in         current_low (index 0), current_high (index 1)
//
// Count, clear and no-op transactions return to idle from the ratio-start state. A
// decision runs three serial divisions on one shared 48-step divider, each launched
// from its own start state, then scales the explore rate when exploring or scans
// the arms for the best estimate otherwise. Reset is asynchronous and active
// low and leaves the block idle. A stalled result holds the block until the
// result transaction completes.
`default_nettype none
module epsilon_greedy_arm_selector #(
  parameter int unsigned NumArms = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tuser: func
  input  wire logic [1:0]  s_axis_tuser,
  // tdata: success_count[15:0], total_count[31:16], measured_current[55:32],
  // explore_draw[71:56], explore_arm[74:72], zero fill
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tuser: explored
  output logic             m_axis_tuser,
  // tdata: next_arm[2:0], reward[19:3], zero fill
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  egas_pkg::cmd_t cmd;
  egas_pkg::sts_t sts;
  logic [2:0]  next_arm;
  logic [16:0] reward;

  assign cfg_ready_o = 1'b1;

  egas_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  egas_dp #(.NumArms(NumArms)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .func_i(s_axis_tuser),
    .success_count_i(s_axis_tdata[15:0]),
    .total_count_i(s_axis_tdata[31:16]),
    .measured_current_i(s_axis_tdata[55:32]),
    .explore_draw_i(s_axis_tdata[71:56]),
    .explore_arm_i(s_axis_tdata[74:72]),
    .next_arm_o(next_arm), .reward_o(reward), .explored_o(m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, reward, next_arm};
endmodule
`default_nettype wire

// ===== src/egas_checker.sv =====
// Port-level checker for the arm selector, bound to the top level.
// Depends on epsilon_greedy_arm_selector.
`default_nettype none
module egas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_rew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:3] <= 17'd65536) else $error("reward range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("busy");
endmodule

bind epsilon_greedy_arm_selector egas_checker u_chk (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the epsilon-greedy arm selector.
// Depends on egas_pkg and epsilon_greedy_arm_selector; predicts every decision itself.
`default_nettype none
module testbench;

  localparam int unsigned NumArms = 6;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0]  next_arm;
    logic [16:0] reward;
    logic        explored;
  } decision_t;

  // One stimulus row: transaction fields, a check flag and the typed-in decision where one is known.
  typedef struct {
    egas_pkg::func_e func;
    logic [15:0] succ;
    logic [15:0] total;
    logic [23:0] cur;
    logic [15:0] draw;
    logic [2:0]  earm;
    bit          known;
    decision_t   want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [79:0] s_axis_tdata = '0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic   m_axis_tuser;
  wire logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  wire logic   cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  epsilon_greedy_arm_selector #(.NumArms(NumArms)) uut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state, mirrors the block.
  logic [23:0] cur_low, cur_high;
  logic [16:0] est_q[NumArms];
  logic [15:0] pulls[NumArms];
  logic [15:0] eps_rate;
  logic [2:0]  arm_now;
  logic [31:0] succ_acc, pkt_acc;

  decision_t pending_decisions[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit calm = 1'b0; // no idling on either side while set

  task automatic report_mismatch(input string what, input int unsigned got, exp_v);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, exp_v, cycle_count);
    error_count++;
  endtask

  function automatic void clear_predictor();
    for (int i = 0; i < NumArms; i++) begin
      est_q[i] = '0;
      pulls[i] = '0;
    end
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Applies one transaction to the predictor; returns 1 with a decision for func decide.
  function automatic bit predict_item(input row_t r, output decision_t d);
    logic [63:0] ratio, norm, rew;
    logic [16:0] est;
    logic [15:0] cnt;
    int unsigned best, a;
    d = '0;
    case (r.func)
      egas_pkg::FuncAdd: begin
        succ_acc = add_sat(succ_acc, r.succ);
        pkt_acc  = add_sat(pkt_acc, r.total);
        return 1'b0;
      end
      egas_pkg::FuncClear: begin
        clear_predictor();
        eps_rate = egas_pkg::RateCleared;
        return 1'b0;
      end
      egas_pkg::FuncDecide: begin
        ratio = 0;
        if (pkt_acc != 0) begin
          ratio = ({32'd0, succ_acc} << 16) / pkt_acc;
          if (ratio > 65536) ratio = 65536;
        end
        if (r.cur <= cur_low) norm = 0;
        else if (r.cur >= cur_high) norm = 65536;
        else norm = (64'(r.cur - cur_low) << 16) / 64'(cur_high - cur_low);
        rew = (3 * ratio + 65536 - norm) >> 2;
        a = arm_now % NumArms;
        cnt = pulls[a];
        if (cnt != 16'hFFFF) cnt++;
        pulls[a] = cnt;
        est = est_q[a];
        if (rew[16:0] >= est) est = est + (rew[16:0] - est) / cnt;
        else est = est - (est - rew[16:0]) / cnt;
        est_q[a] = est;
        if (r.draw < eps_rate) begin
          d.next_arm = 3'(r.earm % NumArms);
          eps_rate = 16'((32'(eps_rate) * 100) / 101);
          d.explored = 1'b1;
        end else begin
          best = 0;
          for (int i = 1; i < NumArms; i++)
            if (est_q[i] > est_q[best]) best = i;
          d.next_arm = 3'(best);
          d.explored = 1'b0;
        end
        d.reward = rew[16:0];
        arm_now = d.next_arm;
        succ_acc = '0;
        pkt_acc = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // Sends one item, waiting for acceptance; queues its prediction. Valid stays
  // high after acceptance until the next item, an idle cycle or a drain replaces it.
  task automatic send_item(input row_t r);
    decision_t d;
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.func;
    s_axis_tdata  <= {5'd0, r.earm, r.draw, r.cur, r.total, r.succ};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_item(r, d)) begin
      // Typed-in expectations in directed rows are checked against the predictor too.
      if (r.known && d != r.want)
        report_mismatch("directed row prediction", d, r.want);
      pending_decisions.push_back(d);
    end
  endtask

  // Writes one register with the block idle; the caller drops valid afterwards.
  task automatic write_reg(input egas_pkg::reg_e idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == egas_pkg::RegCurLow) cur_low = val;
    else cur_high = val;
  endtask

  // Waits for all decisions, then for the worst-case decision latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic row_t mk(egas_pkg::func_e f, int s, int t, int c, int dr, int e);
    row_t r;
    r.func = f; r.succ = 16'(s); r.total = 16'(t); r.cur = 24'(c);
    r.draw = 16'(dr); r.earm = 3'(e); r.known = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_known(row_t r, int arm, int rew, bit ex);
    r.known = 1'b1;
    r.want = '{next_arm: 3'(arm), reward: 17'(rew), explored: ex};
    return r;
  endfunction

  function automatic row_t random_row();
    int unsigned p;
    egas_pkg::func_e f;
    p = $urandom_range(99);
    f = (p < 60) ? egas_pkg::FuncAdd : (p < 92) ? egas_pkg::FuncDecide :
        (p < 96) ? egas_pkg::FuncClear : egas_pkg::FuncNone;
    return mk(f, $urandom, $urandom, $urandom,
              ($urandom_range(3) == 0) ? $urandom_range(70000) : $urandom, $urandom);
  endfunction

  // Result side: random stalls, field-by-field compare.
  always @(posedge clk_i) begin
    decision_t exp_d;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_decisions.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          exp_d = pending_decisions.pop_front();
          if (m_axis_tdata[2:0] != exp_d.next_arm)
            report_mismatch("next_arm", m_axis_tdata[2:0], exp_d.next_arm);
          if (m_axis_tdata[19:3] != exp_d.reward)
            report_mismatch("reward", m_axis_tdata[19:3], exp_d.reward);
          if (m_axis_tuser != exp_d.explored)
            report_mismatch("explored", m_axis_tuser, exp_d.explored);
          if (m_axis_tdata[23:20] != 4'd0)
            report_mismatch("tdata fill", m_axis_tdata[23:20], 0);
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  row_t directed[$];

  initial begin
    cur_low = '0;
    cur_high = 24'hFF_FFFF;
    clear_predictor();
    eps_rate = egas_pkg::RateReset;
    arm_now = '0;
    succ_acc = '0;
    pkt_acc = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right after reset: no packets, zero current gives reward 0.25; draw 0 explores.
    directed.push_back(mk_known(mk(egas_pkg::FuncDecide, 0, 0, 0, 0, 5), 5, 16384, 1'b1));
    // Full delivery at top current: reward 0.75; draw at max exploits arm 5.
    directed.push_back(mk(egas_pkg::FuncAdd, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    directed.push_back(mk_known(mk(egas_pkg::FuncDecide, 0, 0, 24'hFF_FFFF, 16'hFFFF, 0),
                                5, 49152, 1'b0));
    // More successes than packets clamps the ratio.
    directed.push_back(mk(egas_pkg::FuncAdd, 500, 10, 0, 0, 0));
    directed.push_back(mk_known(mk(egas_pkg::FuncDecide, 0, 0, 0, 16'hFFFF, 0),
                                5, 65536, 1'b0));
    // Explore arm out of range wraps.
    directed.push_back(mk(egas_pkg::FuncDecide, 0, 0, 24'h80_0000, 0, 7));
    directed.push_back(mk(egas_pkg::FuncDecide, 0, 0, 24'h12_3456, 0, 6));
    directed.push_back(mk(egas_pkg::FuncNone, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF, 7));
    directed.push_back(mk(egas_pkg::FuncClear, 0, 0, 0, 0, 0));
    directed.push_back(mk(egas_pkg::FuncDecide, 0, 0, 0, egas_pkg::RateCleared - 1, 3));
    directed.push_back(mk(egas_pkg::FuncDecide, 0, 0, 0, egas_pkg::RateCleared, 3));
    // Saturating both accumulators with these values needs 196612 adds; six cover a partial run.
    for (int i = 0; i < 6; i++)
      directed.push_back(mk(egas_pkg::FuncAdd, 16'hAAAA, 16'h5555, 0, 0, 0));
    directed.push_back(mk(egas_pkg::FuncDecide, 0, 0, 24'h55_5555, 16'hFFFF, 2));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // Long run of packet counts with no idling.
    calm = 1'b1;
    repeat (200) send_item(mk(egas_pkg::FuncAdd, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    send_item(mk(egas_pkg::FuncDecide, 0, 0, 1, 16'hFFFF, 1));
    repeat (20) send_item(random_row());
    drain();
    calm = 1'b0;

    // Register settings: mid range, inverted, equal, random, extremes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(egas_pkg::RegCurLow, 24'h00_1000);
          write_reg(egas_pkg::RegCurHigh, 24'h00_9000);
        end
        1: begin
          write_reg(egas_pkg::RegCurLow, 24'hFF_FFFF);
          write_reg(egas_pkg::RegCurHigh, 24'h00_0000);
        end
        2: begin
          write_reg(egas_pkg::RegCurLow, 24'h40_0000);
          write_reg(egas_pkg::RegCurHigh, 24'h40_0000);
        end
        3: begin
          write_reg(egas_pkg::RegCurLow, 24'($urandom));
          write_reg(egas_pkg::RegCurHigh, 24'($urandom));
        end
        default: begin
          write_reg(egas_pkg::RegCurLow, 24'h0);
          write_reg(egas_pkg::RegCurHigh, 24'hFF_FFFF);
        end
      endcase
      cfg_valid_i <= 1'b0;
      repeat (250) begin
        row_t r;
        r = random_row();
        // Half the time, put the current just above the low bound so the interior division is exercised.
        if ($urandom_range(1)) r.cur = cur_low + 24'($urandom_range(40000));
        send_item(r);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/egas_pkg.sv
src/egas_div.sv
src/egas_ctrl.sv
src/egas_dp.sv
src/epsilon_greedy_arm_selector.sv
src/egas_checker.sv
bench/testbench.sv
